@@ hw/rtl/dcc_pkg.sv @@
// Shared types, widths and constants for the drift-corrected calendar clock.
// Holds the month-length lookup used by the date step logic.
// No dependencies.
`default_nettype none

package dcc_pkg;

    localparam int YEAR_W   = 16;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int TICK_W   = 32;
    localparam int PPM_W    = 16;
    localparam int PROD_W   = TICK_W + PPM_W;
    localparam int CORR_W   = 28;
    localparam int BASE_W   = 17;
    localparam int SECS_W   = 26;

    localparam logic FUNC_SYNC  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [SECS_W-1:0] SECS_PER_DAY  = SECS_W'(86400);
    localparam logic [SECS_W-1:0] SECS_PER_HOUR = SECS_W'(3600);
    localparam logic [SECS_W-1:0] SECS_PER_MIN  = SECS_W'(60);

    localparam int CORR_SHIFT = 20;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(524288);
    localparam logic [PROD_W-1:0] ROUND_CEIL = PROD_W'(524288 + 1048575);

    // floor(y / 100) == (y * RECIP_100) >> RECIP_SHIFT for years below 43699
    localparam logic [PPM_W-1:0] RECIP_100   = PPM_W'(5243);
    localparam int               RECIP_SHIFT = 19;
    localparam int               CENT_W      = 10;
    localparam int               CENTURY     = 100;

    localparam logic [YEAR_W-1:0]  RESET_YEAR  = YEAR_W'(2020);
    localparam logic [MONTH_W-1:0] RESET_MONTH = MONTH_W'(1);
    localparam logic [DAY_W-1:0]   RESET_DAY   = DAY_W'(1);

    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    // Out-of-range month codes count as 31-day months.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        if (month == '0 || month > MONTH_DEC) begin
            len = DAY_W'(31);
        end else if (month == MONTH_FEB && leap) begin
            len = DAY_W'(29);
        end else begin
            len = MONTH_LEN[month - MONTH_W'(1)];
        end
        return len;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/drift_corrected_calendar_clock.sv @@
// Drift-corrected calendar clock: top level with the query sequencer.
// Depends on dcc_pkg, dcc_sub and dcc_date_step.
//
// Usage:
// - Input channel (in_valid / in_ready): func = 0 syncs the clock to the given
//   date, time of day and tick_count, and returns nothing. func = 1 queries the
//   time at tick_count and returns one transaction on the output channel.
// - Output channel (out_valid / out_ready): date, HH:MM:SS and synced.
// - cfg_we / cfg_wdata write drift_ppm (signed, per 2^20); write it only while idle.
// - A sync is taken while the sequencer idles and leaves it idle. A query before
//   any sync returns 2020-01-01 00:00:00 with synced = 0; it goes straight to the
//   last step. A synced query multiplies, rounds, sums and runs the leap test;
//   then one subtract-compare unit peels off days, then hours, then minutes, and
//   each year rollover repeats the leap test. One item at a time: in_ready is
//   high only while the sequencer idles. The result sits in an output register;
//   the next transaction is accepted while it waits. A finished query stalls in
//   its last step until that register is free.
// - Reset clears the calendar to 2020-01-01, drift_ppm to 0 and synced to 0.
`default_nettype none

module drift_corrected_calendar_clock import dcc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_we,
    input  wire logic [PPM_W-1:0]   cfg_wdata,

    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               func,
    input  wire logic [TICK_W-1:0]  tick_count,
    input  wire logic [YEAR_W-1:0]  in_year,
    input  wire logic [MONTH_W-1:0] in_month,
    input  wire logic [DAY_W-1:0]   in_day,
    input  wire logic [HOUR_W-1:0]  in_hour,
    input  wire logic [MIN_W-1:0]   in_minute,
    input  wire logic [SEC_W-1:0]   in_second,

    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [YEAR_W-1:0]       out_year,
    output logic [MONTH_W-1:0]      out_month,
    output logic [DAY_W-1:0]        out_day,
    output logic [HOUR_W-1:0]       out_hour,
    output logic [MIN_W-1:0]        out_minute,
    output logic [SEC_W-1:0]        out_second,
    output logic                    synced
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_RND,
        S_SUM,
        S_LEAP_MUL,
        S_LEAP_CHK,
        S_DAY,
        S_HOUR,
        S_MIN,
        S_DONE
    } state_t;

    state_t state_reg;

    // configuration and sync state
    logic [PPM_W-1:0]  drift_ppm_reg;
    date_t             base_date_reg;
    logic [BASE_W-1:0] base_seconds_reg;
    logic [TICK_W-1:0] tick_snapshot_reg;
    logic              has_sync_reg;

    // query working state
    date_t             date_reg;
    logic [TICK_W-1:0] elapsed_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [CORR_W-1:0] corr_mag_reg;
    logic [SECS_W-1:0] secs_reg;
    logic [HOUR_W-1:0] hour_reg;
    logic [MIN_W-1:0]  minute_reg;
    logic              leap_reg;

    // result register
    logic              out_valid_reg;
    date_t             out_date_reg;
    logic [HOUR_W-1:0] out_hour_reg;
    logic [MIN_W-1:0]  out_minute_reg;
    logic [SEC_W-1:0]  out_second_reg;
    logic              out_synced_reg;

    logic              in_fire;
    logic              out_free;
    logic              ppm_neg;
    logic [PPM_W-1:0]  ppm_mag;
    logic [TICK_W-1:0] mul_a;
    logic [PPM_W-1:0]  mul_b;
    logic [PROD_W-1:0] mul_prod;
    logic [PROD_W-1:0] rounded;
    logic [TICK_W:0]   corrected_pos;
    logic [TICK_W-1:0] corrected_neg;
    logic [SECS_W-1:0] secs_add;
    logic [BASE_W-1:0] sync_seconds;
    logic [CENT_W-1:0] century;
    logic [BASE_W-1:0] century_x100;
    logic              leap_calc;
    logic [SECS_W-1:0] divisor;
    logic [SECS_W-1:0] sub_diff;
    logic              sub_ge;
    date_t             date_step;
    logic              year_roll;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_year   = out_date_reg.year;
    assign out_month  = out_date_reg.month;
    assign out_day    = out_date_reg.day;
    assign out_hour   = out_hour_reg;
    assign out_minute = out_minute_reg;
    assign out_second = out_second_reg;
    assign synced     = out_synced_reg;

    // hour*3600 + minute*60 + second always fits in 17 bits
    assign sync_seconds = BASE_W'(in_hour) * BASE_W'(3600)
                        + BASE_W'(in_minute) * BASE_W'(60)
                        + BASE_W'(in_second);

    // Shared multiplier: drift product, then the year/100 reciprocal for leap checks.
    assign ppm_neg  = drift_ppm_reg[PPM_W-1];
    assign ppm_mag  = ppm_neg ? (~drift_ppm_reg + PPM_W'(1)) : drift_ppm_reg;
    assign mul_a    = (state_reg == S_LEAP_MUL) ? TICK_W'(date_reg.year) : elapsed_reg;
    assign mul_b    = (state_reg == S_LEAP_MUL) ? RECIP_100 : ppm_mag;
    assign mul_prod = mul_a * mul_b;

    // Round half up; on the negative side the magnitude plus one half rounds up.
    assign rounded = prod_reg + (ppm_neg ? ROUND_CEIL : ROUND_HALF);

    assign corrected_pos = {1'b0, elapsed_reg} + (TICK_W+1)'(corr_mag_reg);
    assign corrected_neg = (TICK_W'(corr_mag_reg) > elapsed_reg) ? '0
                         : elapsed_reg - TICK_W'(corr_mag_reg);
    assign secs_add = ppm_neg ? SECS_W'(corrected_neg[TICK_W-1:8])
                              : SECS_W'(corrected_pos[TICK_W:8]);

    // Gregorian leap test from the registered year * reciprocal product.
    assign century      = prod_reg[RECIP_SHIFT +: CENT_W];
    assign century_x100 = BASE_W'(century) * BASE_W'(CENTURY);
    assign leap_calc    = (date_reg.year[1:0] == 2'b00)
                        && ((century_x100 != BASE_W'(date_reg.year)) || (century[1:0] == 2'b00));

    always_comb
    begin
        unique case (state_reg)
            S_DAY:   divisor = SECS_PER_DAY;
            S_HOUR:  divisor = SECS_PER_HOUR;
            default: divisor = SECS_PER_MIN;
        endcase
    end

    dcc_sub u_sub (
        .minuend    (secs_reg),
        .subtrahend (divisor),
        .diff       (sub_diff),
        .ge         (sub_ge)
    );

    dcc_date_step u_date_step (
        .date_in   (date_reg),
        .leap      (leap_reg),
        .date_out  (date_step),
        .year_roll (year_roll)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg         <= S_IDLE;
            drift_ppm_reg     <= '0;
            base_date_reg     <= '{year: RESET_YEAR, month: RESET_MONTH, day: RESET_DAY};
            base_seconds_reg  <= '0;
            tick_snapshot_reg <= '0;
            has_sync_reg      <= 1'b0;
            date_reg          <= '0;
            elapsed_reg       <= '0;
            prod_reg          <= '0;
            corr_mag_reg      <= '0;
            secs_reg          <= '0;
            hour_reg          <= '0;
            minute_reg        <= '0;
            leap_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
            out_date_reg      <= '0;
            out_hour_reg      <= '0;
            out_minute_reg    <= '0;
            out_second_reg    <= '0;
            out_synced_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                drift_ppm_reg <= cfg_wdata;
            end

            // drop the result once the receiver takes it, unless a new one loads now
            if (out_valid_reg && out_ready && state_reg != S_DONE) begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire) begin
                        if (func == FUNC_SYNC) begin
                            base_date_reg     <= '{year: in_year, month: in_month, day: in_day};
                            base_seconds_reg  <= sync_seconds;
                            tick_snapshot_reg <= tick_count;
                            has_sync_reg      <= 1'b1;
                        end else begin
                            date_reg    <= base_date_reg;
                            elapsed_reg <= tick_count - tick_snapshot_reg;
                            secs_reg    <= '0;
                            hour_reg    <= '0;
                            minute_reg  <= '0;
                            state_reg   <= has_sync_reg ? S_MUL : S_DONE;
                        end
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= mul_prod;
                    state_reg <= S_RND;
                end
                S_RND:
                begin
                    // a zero product gives no correction on either side
                    corr_mag_reg <= (prod_reg == '0) ? '0
                                  : rounded[CORR_SHIFT +: CORR_W];
                    state_reg    <= S_SUM;
                end
                S_SUM:
                begin
                    secs_reg  <= SECS_W'(base_seconds_reg) + secs_add;
                    state_reg <= S_LEAP_MUL;
                end
                S_LEAP_MUL:
                begin
                    prod_reg  <= mul_prod;
                    state_reg <= S_LEAP_CHK;
                end
                S_LEAP_CHK:
                begin
                    leap_reg  <= leap_calc;
                    state_reg <= S_DAY;
                end
                S_DAY:
                begin
                    if (sub_ge) begin
                        secs_reg <= sub_diff;
                        date_reg <= date_step;
                        // new year: redo the leap test before the next day
                        if (year_roll) begin
                            state_reg <= S_LEAP_MUL;
                        end
                    end else begin
                        state_reg <= S_HOUR;
                    end
                end
                S_HOUR:
                begin
                    if (sub_ge) begin
                        secs_reg <= sub_diff;
                        hour_reg <= hour_reg + HOUR_W'(1);
                    end else begin
                        state_reg <= S_MIN;
                    end
                end
                S_MIN:
                begin
                    if (sub_ge) begin
                        secs_reg   <= sub_diff;
                        minute_reg <= minute_reg + MIN_W'(1);
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    // hold until the result register is free
                    if (out_free) begin
                        out_valid_reg  <= 1'b1;
                        out_date_reg   <= date_reg;
                        out_hour_reg   <= hour_reg;
                        out_minute_reg <= minute_reg;
                        out_second_reg <= secs_reg[SEC_W-1:0];
                        out_synced_reg <= has_sync_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Unsynced results always carry the reset date at midnight.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !synced) |-> (out_year == RESET_YEAR && out_month == RESET_MONTH
            && out_day == RESET_DAY && out_hour == '0 && out_minute == '0
            && out_second == '0))
        else $error("unsynced result is not the reset date and time");

    // Whole days and hours are peeled off before the time fields are formed.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_hour < HOUR_W'(24) && out_minute < MIN_W'(60)
            && out_second < SEC_W'(60)))
        else $error("time of day out of range");

    // A sync transaction marks the clock synced from the next cycle on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && func == FUNC_SYNC) |=> has_sync_reg)
        else $error("sync transaction did not set the synced flag");

    // A result is only loaded while the result register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !out_ready) |=> (state_reg == S_DONE))
        else $error("result overwritten while the receiver stalls");

endmodule

`default_nettype wire

@@ hw/rtl/dcc_sub.sv @@
// Shared subtract-and-compare unit of the calendar clock sequencer.
// Depends on dcc_pkg (SECS_W).
`default_nettype none

module dcc_sub import dcc_pkg::*;
(
    input  wire logic [SECS_W-1:0] minuend,
    input  wire logic [SECS_W-1:0] subtrahend,
    output logic      [SECS_W-1:0] diff,
    output logic                   ge
);

    logic [SECS_W:0] wide_diff;

    assign wide_diff = {1'b0, minuend} - {1'b0, subtrahend};
    assign diff      = wide_diff[SECS_W-1:0];
    // no borrow out means minuend >= subtrahend
    assign ge        = ~wide_diff[SECS_W];

endmodule

`default_nettype wire

@@ hw/rtl/dcc_date_step.sv @@
// One-day advance of a Gregorian date, with month and year rollover.
// Depends on dcc_pkg (date_t, month_days).
`default_nettype none

module dcc_date_step import dcc_pkg::*;
(
    input  wire date_t date_in,
    input  wire logic  leap,
    output date_t      date_out,
    output logic       year_roll
);

    logic [DAY_W:0]   day_inc;
    logic [DAY_W-1:0] max_day;

    assign day_inc = {1'b0, date_in.day} + (DAY_W+1)'(1);
    assign max_day = month_days(date_in.month, leap);

    always_comb
    begin
        date_out  = date_in;
        year_roll = 1'b0;
        if (day_inc > {1'b0, max_day}) begin
            date_out.day = DAY_W'(1);
            if (date_in.month >= MONTH_DEC) begin
                date_out.month = MONTH_W'(1);
                date_out.year  = date_in.year + YEAR_W'(1);
                year_roll      = 1'b1;
            end else begin
                date_out.month = date_in.month + MONTH_W'(1);
            end
        end else begin
            date_out.day = day_inc[DAY_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/drift_corrected_calendar_clock_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the drift-corrected calendar clock.
// Depends on dcc_pkg and drift_corrected_calendar_clock; drives both
// valid/ready channels with random idling and predicts every query result.

module drift_corrected_calendar_clock_tb;
    import dcc_pkg::*;

    // Run-level constants
    localparam int          SETTLE_CYCLES = 400;        // above the worst query latency
    localparam int          LONG_HOLD     = 400;        // receiver hold-off for back-pressure
    localparam int          TIME_LIMIT_NS = 3_000_000;
    localparam int unsigned DAY_SECONDS   = 86400;
    localparam int unsigned HOUR_SECONDS  = 3600;
    localparam int unsigned DAY_TICKS     = DAY_SECONDS * 256;

    // One input transaction as the sender sees it
    typedef struct packed {
        logic               op;
        logic [TICK_W-1:0]  ticks;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } clock_item_t;

    // One output transaction: the calendar reading of a query
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
        logic               synced;
    } clock_reading_t;

    // DUT connections; every input starts at a known value
    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               cfg_we     = 1'b0;
    logic [PPM_W-1:0]   cfg_wdata  = '0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic               func       = FUNC_SYNC;
    logic [TICK_W-1:0]  tick_count = '0;
    logic [YEAR_W-1:0]  in_year    = '0;
    logic [MONTH_W-1:0] in_month   = '0;
    logic [DAY_W-1:0]   in_day     = '0;
    logic [HOUR_W-1:0]  in_hour    = '0;
    logic [MIN_W-1:0]   in_minute  = '0;
    logic [SEC_W-1:0]   in_second  = '0;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic [YEAR_W-1:0]  out_year;
    logic [MONTH_W-1:0] out_month;
    logic [DAY_W-1:0]   out_day;
    logic [HOUR_W-1:0]  out_hour;
    logic [MIN_W-1:0]   out_minute;
    logic [SEC_W-1:0]   out_second;
    logic               synced;

    // Predictor state: the calendar base, tick snapshot and drift setting
    logic [YEAR_W-1:0]  cal_year   = RESET_YEAR;
    logic [MONTH_W-1:0] cal_month  = RESET_MONTH;
    logic [DAY_W-1:0]   cal_day    = RESET_DAY;
    logic [BASE_W-1:0]  cal_secs   = '0;
    logic [TICK_W-1:0]  snap_ticks = '0;
    logic               have_sync  = 1'b0;
    logic [PPM_W-1:0]   drift_ppm_model = '0;

    clock_reading_t expected_readings[$];
    int             mismatches  = 0;
    bit             quiet_tail  = 1'b0;   // no idling on either side when set
    bit             hold_output = 1'b0;   // request one long receiver hold-off

    drift_corrected_calendar_clock uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .tick_count (tick_count),
        .in_year    (in_year),
        .in_month   (in_month),
        .in_day     (in_day),
        .in_hour    (in_hour),
        .in_minute  (in_minute),
        .in_second  (in_second),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_year   (out_year),
        .out_month  (out_month),
        .out_day    (out_day),
        .out_hour   (out_hour),
        .out_minute (out_minute),
        .out_second (out_second),
        .synced     (synced)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Hard stop in case a handshake never completes
    initial
    begin
        #TIME_LIMIT_NS;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------

    // Gregorian month length; month codes outside 1..12 count as 31 days
    function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
        bit leap;
        leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
        case (m)
            2:             return leap ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // Work out the reading a query at the given tick count returns
    function automatic clock_reading_t predict_reading(input logic [TICK_W-1:0] ticks);
        clock_reading_t    rd;
        logic [TICK_W-1:0] elapsed;
        logic [PPM_W:0]    mag;
        logic [63:0]       prod;
        longint            corrected;
        int unsigned       total;
        int unsigned       days;
        int unsigned       y;
        int unsigned       m;
        int unsigned       d;
        y     = cal_year;
        m     = cal_month;
        d     = cal_day;
        total = 0;
        if (have_sync)
        begin
            // Wrapping tick difference, then the ppm correction: the product plus one
            // half, rounded up for negative drift, before the floor shift by 20
            elapsed   = ticks - snap_ticks;
            mag       = drift_ppm_model[PPM_W-1] ? (17'h10000 - {1'b0, drift_ppm_model})
                                                 : {1'b0, drift_ppm_model};
            prod      = 64'(elapsed) * 64'(mag);
            corrected = longint'({32'd0, elapsed});
            if (!drift_ppm_model[PPM_W-1] || prod == 64'd0)
                corrected = corrected + longint'((prod + 64'd524288) >> 20);
            else
                corrected = corrected - longint'((prod + 64'd1572863) >> 20);
            if (corrected < 0)
                corrected = 0;
            total = cal_secs + 32'(corrected >> 8);
            days  = total / DAY_SECONDS;
            total = total % DAY_SECONDS;
            // Advance the date one day at a time
            for (int unsigned k = 0; k < days; k++)
            begin
                if (d + 1 > days_in_month(y, m))
                begin
                    d = 1;
                    m = m + 1;
                    if (m > 12)
                    begin
                        m = 1;
                        y = (y + 1) & 32'hFFFF;
                    end
                end
                else
                begin
                    d = d + 1;
                end
            end
        end
        rd.year   = 16'(y);
        rd.month  = 4'(m);
        rd.day    = 5'(d);
        rd.hour   = 5'(total / HOUR_SECONDS);
        rd.minute = 6'((total % HOUR_SECONDS) / 60);
        rd.second = 6'(total % 60);
        rd.synced = have_sync;
        return rd;
    endfunction

    // ------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------

    function automatic clock_item_t make_sync(input int unsigned y, input int unsigned m,
                                              input int unsigned d, input int unsigned h,
                                              input int unsigned mi, input int unsigned s,
                                              input logic [TICK_W-1:0] ticks);
        clock_item_t it;
        it.op     = FUNC_SYNC;
        it.ticks  = ticks;
        it.year   = 16'(y);
        it.month  = 4'(m);
        it.day    = 5'(d);
        it.hour   = 5'(h);
        it.minute = 6'(mi);
        it.second = 6'(s);
        return it;
    endfunction

    // Query with random noise on the date fields, which the block ignores
    function automatic clock_item_t make_query(input logic [TICK_W-1:0] ticks);
        clock_item_t it;
        it       = make_sync($urandom(), $urandom(), $urandom(), $urandom(),
                             $urandom(), $urandom(), ticks);
        it.op    = FUNC_QUERY;
        return it;
    endfunction

    // Mostly well-formed syncs and queries at tiny, day-scale or huge
    // distances from the last snapshot; the rest raw field noise
    function automatic clock_item_t random_item();
        clock_item_t it;
        int unsigned pick;
        int unsigned y;
        int unsigned m;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            it = make_sync($urandom(), $urandom(), $urandom(), $urandom(),
                           $urandom(), $urandom(), $urandom());
            if (pick < 29)
            begin
                case ($urandom_range(0, 3))
                    0:       y = 16'hFFFF;
                    1:       y = 1900 + 100 * $urandom_range(0, 4);
                    default: y = $urandom_range(0, 16'hFFFF);
                endcase
                m  = $urandom_range(1, 12);
                it = make_sync(y, m, $urandom_range(1, days_in_month(y, m)),
                               $urandom_range(0, 23), $urandom_range(0, 59),
                               $urandom_range(0, 59), $urandom());
            end
        end
        else if (pick < 55)
            it = make_query(snap_ticks + $urandom_range(0, 511));
        else if (pick < 80)
            it = make_query(snap_ticks + $urandom_range(0, 3 * DAY_TICKS));
        else
            it = make_query($urandom());
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Sender, receiver and result checker
    // ------------------------------------------------------------------

    // Offer one transaction and hold it until accepted. Valid stays high
    // afterwards; the next call or wait_idle changes it in the same step.
    task automatic send_item(input clock_item_t it);
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= it.op;
        tick_count <= it.ticks;
        in_year    <= it.year;
        in_month   <= it.month;
        in_day     <= it.day;
        in_hour    <= it.hour;
        in_minute  <= it.minute;
        in_second  <= it.second;
        do
            @(posedge clk);
        while (!in_ready);
        // Accepted at this edge: update the predictor
        if (it.op == FUNC_SYNC)
        begin
            cal_year   = it.year;
            cal_month  = it.month;
            cal_day    = it.day;
            cal_secs   = BASE_W'(it.hour * HOUR_SECONDS + it.minute * 60 + it.second);
            snap_ticks = it.ticks;
            have_sync  = 1'b1;
        end
        else
        begin
            expected_readings.push_back(predict_reading(it.ticks));
        end
    endtask

    // Drop valid, wait for every expected reading, then let a trailing
    // sync (which returns nothing) finish before anything else happens
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_drift(input logic [PPM_W-1:0] ppm);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= ppm;
        @(posedge clk);
        cfg_we          <= 1'b0;
        drift_ppm_model  = ppm;
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_item(random_item());
    endtask

    // Receiver: random stall bursts, one long hold-off on request,
    // always ready during the quiet tail
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (hold_output)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_output = 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Compare each output transaction with the oldest expected reading
    always @(posedge clk)
    begin
        clock_reading_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_readings.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: unexpected reading, expected none, actual %0d-%0d-%0d %0d:%0d:%0d",
                         $time, out_year, out_month, out_day, out_hour, out_minute, out_second);
            end
            else
            begin
                want = expected_readings.pop_front();
                check_field("year",   want.year,   out_year);
                check_field("month",  want.month,  out_month);
                check_field("day",    want.day,    out_day);
                check_field("hour",   want.hour,   out_hour);
                check_field("minute", want.minute, out_minute);
                check_field("second", want.second, out_second);
                check_field("synced", want.synced, synced);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Queries before any sync return the reset date at midnight, unsynced
    task automatic test_unsynced_queries();
        send_item(make_query('0));
        send_item(make_query('1));
        send_item(make_query($urandom()));
    endtask

    // Calendar corner cases with no drift correction
    task automatic test_calendar_edges();
        set_drift('0);
        // Year wraps from 65535 to 0 one second after New Year's Eve midnight
        send_item(make_sync(16'hFFFF, 12, 31, 23, 59, 59, 1000));
        send_item(make_query(1000 + 256));
        send_item(make_query(1000));
        // Leap rules: divisible by 400, by 100 only, by 4
        send_item(make_sync(2000, 2, 28, 12, 0, 0, 0));
        send_item(make_query(DAY_TICKS));
        send_item(make_sync(1900, 2, 28, 0, 0, 0, 5));
        send_item(make_query(5 + DAY_TICKS));
        send_item(make_sync(2024, 2, 29, 6, 30, 15, 77));
        send_item(make_query(77 + DAY_TICKS + 255));
        // Month code 0 with the widest time fields spills a day at once
        send_item(make_sync(1999, 0, 31, 31, 63, 63, 0));
        send_item(make_query(0));
        // Month code 15 rolls into January of the next year
        send_item(make_sync(2030, 15, 31, 0, 0, 0, 9));
        send_item(make_query(9 + DAY_TICKS));
        // Day past the month end, and day 0
        send_item(make_sync(2023, 2, 30, 1, 2, 3, 0));
        send_item(make_query(DAY_TICKS));
        send_item(make_sync(2023, 6, 0, 0, 0, 0, 0));
        send_item(make_query(0));
        // Tick counter wraps between sync and query
        send_item(make_sync(2021, 7, 4, 10, 0, 0, 32'hFFFF_FF00));
        send_item(make_query(32'h0000_0100));
        // Largest elapsed count
        send_item(make_sync(2021, 7, 4, 10, 0, 0, 1));
        send_item(make_query(0));
    endtask

    // Extreme and random drift settings, each with a random phase
    task automatic test_drift_sweep();
        logic [PPM_W-1:0] settings[5];
        settings = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'($urandom())};
        foreach (settings[i])
        begin
            set_drift(settings[i]);
            // Give the largest elapsed count under each setting
            send_item(make_sync(2020, 1, 1, 0, 0, 0, 1));
            send_item(make_query(0));
            run_random(95);
        end
    endtask

    // Hold the output off for a long stretch while short queries keep coming,
    // so the output register fills and the input stalls
    task automatic test_output_backpressure();
        set_drift(16'($urandom()));
        send_item(make_sync(2022, 3, 14, 1, 59, 26, $urandom()));
        hold_output = 1'b1;
        for (int i = 0; i < 10; i++)
            send_item(make_query(snap_ticks + $urandom_range(0, 2047)));
    endtask

    task automatic test_random_mix();
        set_drift(16'($urandom()));
        run_random(300);
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_quiet_tail();
        set_drift(16'($urandom()));
        quiet_tail = 1'b1;
        run_random(140);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_unsynced_queries();
        test_calendar_edges();
        test_drift_sweep();
        test_output_backpressure();
        test_random_mix();
        test_quiet_tail();
        wait_idle();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/dcc_pkg.sv
hw/rtl/dcc_sub.sv
hw/rtl/dcc_date_step.sv
hw/rtl/drift_corrected_calendar_clock.sv
tb/sv/drift_corrected_calendar_clock_tb.sv
